// ===== src/isst_pkg.sv =====
// Shared constants, types and the square-root digit step for the membership test.
package isst_pkg;

    // Joint count of the configuration and how many of them are tested.
    localparam int NJOINT = 4;
    localparam int DOF    = 4;

    localparam int COORD_W = 16;              // signed Q3.12 coordinate
    localparam int DIFF_W  = COORD_W + 1;     // signed difference
    localparam int SQ_W    = 2 * COORD_W;     // one squared magnitude
    localparam int SS_W    = SQ_W + 2;        // sum of four squares
    localparam int ROOT_W  = SS_W / 2;        // floor root of the sum
    localparam int REM_W   = ROOT_W + 2;      // partial remainder
    localparam int LEN_W   = 19;              // unsigned Q7.12 length

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COST      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNBOUNDED = 3'd5;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_st;

    // One restoring digit step: bring down two radicand bits, try 4*root+1.
    function automatic t_sqrt_st sqrt_step(input t_sqrt_st cur, input logic [1:0] pair);
        logic [REM_W+1:0] t_rem;
        logic [REM_W+1:0] t_trial;
        t_sqrt_st         nxt;
        t_rem   = {cur.rem, pair};
        t_trial = {{(REM_W - ROOT_W){1'b0}}, cur.root, 2'b01};
        if (t_rem >= t_trial) begin
            nxt.rem  = REM_W'(t_rem - t_trial);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = t_rem[REM_W-1:0];
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

// ===== src/isst_in_if.sv =====
// Input channel: one joint configuration per transfer.
interface isst_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   joint_0;
    logic signed [15:0]   joint_1;
    logic signed [15:0]   joint_2;
    logic signed [15:0]   joint_3;

    modport source (output valid, joint_0, joint_1, joint_2, joint_3, input ready);
    modport sink   (input valid, joint_0, joint_1, joint_2, joint_3, output ready);
endinterface

// ===== src/isst_out_if.sv =====
// Output channel: one membership result per transfer.
interface isst_out_if;
    logic        valid;
    logic        ready;
    logic        within_limits;
    logic        inside_set;
    logic [18:0] path_length;

    modport source (output valid, within_limits, inside_set, path_length, input ready);
    modport sink   (input valid, within_limits, inside_set, path_length, output ready);
endinterface

// ===== src/informed_set_membership_test_core.sv =====
// Informed-set membership test: joint limit check plus start/goal distance bound.
// Throughput: one configuration per cycle while not stalled; the 17-stage square-root pipelines
//   (one root bit per stage) set the depth, every stage takes a new item each unstalled cycle.
// Backpressure stalls the whole pipeline in place while the output register holds an untaken result.
// Reset (synchronous, active low) clears all valid bits and the configuration
//   registers; r_unbounded resets to 1.
module informed_set_membership_test_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    isst_in_if.sink                            i_in,
    isst_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [isst_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [isst_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NJ  = isst_pkg::NJOINT;
    localparam int CW  = isst_pkg::COORD_W;
    localparam int DW  = isst_pkg::DIFF_W;
    localparam int QW  = isst_pkg::SQ_W;
    localparam int SW  = isst_pkg::SS_W;
    localparam int RW  = isst_pkg::ROOT_W;
    localparam int LW  = isst_pkg::LEN_W;
    localparam int NSQ = isst_pkg::ROOT_W;   // stages in each root pipeline

    // ---------------- configuration registers ----------------
    logic [isst_pkg::CFG_DATA_W-1:0] r_lower, r_upper, r_start, r_goal;
    logic [LW-1:0]                   r_cost;
    logic                            r_unbounded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower     <= '0;
            r_upper     <= '0;
            r_start     <= '0;
            r_goal      <= '0;
            r_cost      <= '0;
            r_unbounded <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                isst_pkg::CFG_LOWER:     r_lower     <= i_cfg_data;
                isst_pkg::CFG_UPPER:     r_upper     <= i_cfg_data;
                isst_pkg::CFG_START:     r_start     <= i_cfg_data;
                isst_pkg::CFG_GOAL:      r_goal      <= i_cfg_data;
                isst_pkg::CFG_COST:      r_cost      <= i_cfg_data[LW-1:0];
                isst_pkg::CFG_UNBOUNDED: r_unbounded <= i_cfg_data[0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Single stall: everything advances unless the output holds an untaken result.
    logic r_ov;
    logic w_en;
    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------- stage 1: differences and limit checks ----------------
    logic signed [CW-1:0] w_q [NJ];
    assign w_q[0] = i_in.joint_0;
    assign w_q[1] = i_in.joint_1;
    assign w_q[2] = i_in.joint_2;
    assign w_q[3] = i_in.joint_3;

    logic signed [DW-1:0] r1_ds [NJ];
    logic signed [DW-1:0] r1_dg [NJ];
    logic signed [DW-1:0] n1_ds [NJ];
    logic signed [DW-1:0] n1_dg [NJ];
    logic                 n1_w;
    logic                 r1_w, r1_v;

    always_comb begin
        n1_w = 1'b1;
        for (int j = 0; j < NJ; j++) begin
            if (j < isst_pkg::DOF) begin
                n1_ds[j] = DW'(w_q[j]) - DW'($signed(r_start[CW*j +: CW]));
                n1_dg[j] = DW'(w_q[j]) - DW'($signed(r_goal[CW*j +: CW]));
                if (w_q[j] > $signed(r_upper[CW*j +: CW]) ||
                    w_q[j] < $signed(r_lower[CW*j +: CW])) begin
                    n1_w = 1'b0;
                end
            end else begin
                // joint beyond DOF: no distance, no limit check
                n1_ds[j] = '0;
                n1_dg[j] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ds <= n1_ds;
            r1_dg <= n1_dg;
            r1_w  <= n1_w;
        end
    end

    // ---------------- stage 2: magnitudes ----------------
    logic [CW-1:0] r2_as [NJ];
    logic [CW-1:0] r2_ag [NJ];
    logic          r2_w, r2_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < NJ; j++) begin
                // |diff| never exceeds 65535, so 16 bits hold it
                r2_as[j] <= r1_ds[j][DW-1] ? CW'(-r1_ds[j]) : CW'(r1_ds[j]);
                r2_ag[j] <= r1_dg[j][DW-1] ? CW'(-r1_dg[j]) : CW'(r1_dg[j]);
            end
            r2_w <= r1_w;
        end
    end

    // ---------------- stage 3: squares ----------------
    logic [QW-1:0] r3_ss [NJ];
    logic [QW-1:0] r3_sg [NJ];
    logic          r3_w, r3_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < NJ; j++) begin
                r3_ss[j] <= r2_as[j] * r2_as[j];
                r3_sg[j] <= r2_ag[j] * r2_ag[j];
            end
            r3_w <= r2_w;
        end
    end

    // ---------------- stage 4: pair sums ----------------
    logic [QW:0] r4_ps [2];
    logic [QW:0] r4_pg [2];
    logic        r4_w, r4_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int p = 0; p < 2; p++) begin
                r4_ps[p] <= (QW+1)'(r3_ss[2*p]) + (QW+1)'(r3_ss[2*p+1]);
                r4_pg[p] <= (QW+1)'(r3_sg[2*p]) + (QW+1)'(r3_sg[2*p+1]);
            end
            r4_w <= r3_w;
        end
    end

    // ---------------- stage 5: full sums of squares ----------------
    logic [SW-1:0] r5_xs, r5_xg;
    logic          r5_w, r5_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_xs <= SW'(r4_ps[0]) + SW'(r4_ps[1]);
            r5_xg <= SW'(r4_pg[0]) + SW'(r4_pg[1]);
            r5_w  <= r4_w;
        end
    end

    // ---------------- stages 6..22: floor square roots ----------------
    logic [RW-1:0] w_root_s, w_root_g;

    isst_isqrt u_sqrt_start (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r5_xs),
        .o_root (w_root_s)
    );

    isst_isqrt u_sqrt_goal (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_x    (r5_xg),
        .o_root (w_root_g)
    );

    // within flag and valid bit ride alongside the root pipelines
    logic r_wq [NSQ];
    logic r_vq [NSQ];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wq[0] <= r5_w;
            for (int k = 1; k < NSQ; k++) begin
                r_wq[k] <= r_wq[k-1];
            end
        end
    end

    // ---------------- stage 23: summed length ----------------
    // Two 17-bit roots sum below 2^18, so the 19-bit length never saturates.
    logic [LW-1:0] r6_len;
    logic          r6_w, r6_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_len <= LW'(w_root_s) + LW'(w_root_g);
            r6_w   <= r_wq[NSQ-1];
        end
    end

    // ---------------- stage 24: cost compare into output register ----------------
    logic          r_o_within, r_o_inside;
    logic [LW-1:0] r_o_len;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_within <= r6_w;
            r_o_inside <= r6_w && (r_unbounded || (r6_len < r_cost));
            r_o_len    <= r6_len;
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            for (int k = 0; k < NSQ; k++) begin
                r_vq[k] <= 1'b0;
            end
            r6_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r1_v    <= i_in.valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r_vq[0] <= r5_v;
            for (int k = 1; k < NSQ; k++) begin
                r_vq[k] <= r_vq[k-1];
            end
            r6_v <= r_vq[NSQ-1];
            r_ov <= r6_v;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.within_limits = r_o_within;
    assign o_out.inside_set    = r_o_inside;
    assign o_out.path_length   = r_o_len;

endmodule

// ===== src/isst_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module isst_isqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [isst_pkg::SS_W-1:0]     i_x,
    output logic [isst_pkg::ROOT_W-1:0]   o_root
);

    localparam int NSTG = isst_pkg::ROOT_W;

    logic [isst_pkg::SS_W-1:0] r_x [NSTG];
    isst_pkg::t_sqrt_st        r_st [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        // stage k consumes the radicand pair at the next lower bit position
        localparam int LO = 2 * (NSTG - 1 - k);
        if (k == 0) begin : g_first
            isst_pkg::t_sqrt_st n_st;
            always_comb begin
                n_st = isst_pkg::sqrt_step('0, i_x[LO+1:LO]);
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k]  <= i_x;
                    r_st[k] <= n_st;
                end
            end
        end else begin : g_next
            isst_pkg::t_sqrt_st n_st;
            always_comb begin
                n_st = isst_pkg::sqrt_step(r_st[k-1], r_x[k-1][LO+1:LO]);
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k]  <= r_x[k-1];
                    r_st[k] <= n_st;
                end
            end
        end
    end

    assign o_root = r_st[NSTG-1].root;

endmodule

// ===== verif/informed_set_membership_test_core_test.sv =====
// Self-checking testbench for the informed-set membership test core.
`timescale 1ns / 100ps

module informed_set_membership_test_core_test;
    import isst_pkg::*;

    // Register indexes past the last mapped one: writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int          PIPE_LATENCY = 24;            // input transfer to result
    localparam longint      LEN_CAP      = (1 << LEN_W) - 1;
    localparam int          PHASE_ITEMS  = 160;
    localparam int          BURST_ITEMS  = 180;
    localparam int          MAX_PRINTS   = 40;

    // How the cost bound is set up for one random phase.
    typedef enum logic [1:0] {COST_OPEN, COST_NEAR, COST_ZERO, COST_FULL} t_cost_mode;

    // One predicted result, kept with the joints that produced it for reporting.
    typedef struct packed {
        logic [63:0]      joints;
        logic             in_limits;
        logic             in_set;
        logic [LEN_W-1:0] length;
    } t_verdict;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    isst_in_if  in_ch ();
    isst_out_if out_ch ();

    informed_set_membership_test_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Testbench copy of the configuration registers, updated on every write.
    logic [63:0]      lower_cfg;
    logic [63:0]      upper_cfg;
    logic [63:0]      start_cfg;
    logic [63:0]      goal_cfg;
    logic [LEN_W-1:0] cost_cfg;
    logic             unbounded_cfg;

    t_verdict    pending_verdicts[$];
    int unsigned mismatch_count;
    bit          idle_en;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Floor square root, built one root bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Limit check, start and goal distances, and the cost decision for one candidate.
    function automatic t_verdict judge_candidate(input logic [63:0] joints);
        t_verdict           v;
        logic signed [15:0] q;
        longint             ds;
        longint             dg;
        longint unsigned    ss_start;
        longint unsigned    ss_goal;
        longint unsigned    len;
        v.joints    = joints;
        v.in_limits = 1'b1;
        ss_start = 0;
        ss_goal  = 0;
        for (int j = 0; j < DOF; j++) begin
            q  = joints[16*j +: 16];
            ds = q - $signed(start_cfg[16*j +: 16]);
            dg = q - $signed(goal_cfg[16*j +: 16]);
            if (q > $signed(upper_cfg[16*j +: 16]) || q < $signed(lower_cfg[16*j +: 16])) begin
                v.in_limits = 1'b0;
            end
            ss_start += ds * ds;
            ss_goal  += dg * dg;
        end
        len = floor_root(ss_start) + floor_root(ss_goal);
        if (len > LEN_CAP) begin
            len = LEN_CAP;
        end
        v.length = len[LEN_W-1:0];
        v.in_set = v.in_limits && (unbounded_cfg || (len < cost_cfg));
        return v;
    endfunction

    function automatic logic [63:0] pack4(input int j0, input int j1, input int j2, input int j3);
        return {16'(j3), 16'(j2), 16'(j1), 16'(j0)};
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    // Every output transfer is compared against the oldest prediction.
    always @(posedge i_clk) begin : check_result
        t_verdict want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("output transfer with nothing pending");
            end else begin
                want = pending_verdicts.pop_front();
                if (out_ch.within_limits !== want.in_limits) begin
                    report_mismatch($sformatf("joints %h: within_limits %b, want %b",
                                              want.joints, out_ch.within_limits, want.in_limits));
                end
                if (out_ch.inside_set !== want.in_set) begin
                    report_mismatch($sformatf("joints %h: inside_set %b, want %b",
                                              want.joints, out_ch.inside_set, want.in_set));
                end
                if (out_ch.path_length !== want.length) begin
                    report_mismatch($sformatf("joints %h: path_length %0d, want %0d",
                                              want.joints, out_ch.path_length, want.length));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Result side: ready drops at random while idling is on.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 7) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Register write; only called with nothing in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (index)
            CFG_LOWER:     lower_cfg     = data;
            CFG_UPPER:     upper_cfg     = data;
            CFG_START:     start_cfg     = data;
            CFG_GOAL:      goal_cfg      = data;
            CFG_COST:      cost_cfg      = data[LEN_W-1:0];
            CFG_UNBOUNDED: unbounded_cfg = data[0];
            default:       ;
        endcase
    endtask

    // Offers one candidate, maybe after a gap, and logs the prediction on transfer.
    // Valid stays high into the next call unless a gap or a drain lowers it.
    task automatic offer_candidate(input logic [63:0] joints);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid   = 1'b1;
        in_ch.joint_0 = joints[15:0];
        in_ch.joint_1 = joints[31:16];
        in_ch.joint_2 = joints[47:32];
        in_ch.joint_3 = joints[63:48];
        do @(posedge i_clk); while (!in_ch.ready);
        pending_verdicts.push_back(judge_candidate(joints));
    endtask

    // Stop offering and wait for every predicted result; the timeout guards a hang.
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // Candidate mix: mostly near the start-goal segment or inside the limits,
    // some right on or just past a limit, and some fully random.
    function automatic logic [63:0] gen_candidate();
        logic [63:0] v;
        int          s, g, lo, hi, p, off, t, spread, pick;
        int unsigned mode;
        mode   = $urandom_range(0, 9);
        t      = $urandom_range(0, 256);
        spread = 1 << $urandom_range(0, 14);
        for (int j = 0; j < NJOINT; j++) begin
            s  = $signed(start_cfg[16*j +: 16]);
            g  = $signed(goal_cfg[16*j +: 16]);
            lo = $signed(lower_cfg[16*j +: 16]);
            hi = $signed(upper_cfg[16*j +: 16]);
            if (mode <= 4) begin
                off = $urandom_range(0, 2 * spread);
                off = off - spread;
                p   = s + ((g - s) * t) / 256 + off;
            end else if (mode <= 6) begin
                off = $urandom_range(0, (hi >= lo) ? hi - lo : 0);
                p   = (hi >= lo) ? lo + off : hi;
            end else if (mode == 7) begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0:       p = lo;
                    1:       p = hi;
                    2:       p = lo - 1;
                    default: p = hi + 1;
                endcase
            end else begin
                off = $urandom_range(0, 65535);
                p   = off - 32768;
            end
            if (p > 32767) begin
                p = 32767;
            end else if (p < -32768) begin
                p = -32768;
            end
            v[16*j +: 16] = 16'(p);
        end
        return v;
    endfunction

    // New limits, start, goal and cost bound for one random phase.
    // Start and goal are drawn inside the limits; now and then one lane gets inverted limits.
    task automatic load_random_phase(input t_cost_mode cost_mode);
        logic [63:0]      lo_v, hi_v, st_v, gl_v, junk;
        logic [15:0]      swap;
        logic [LEN_W-1:0] cost;
        int               a, b, r, k;
        bit               wide;
        t_verdict         base;
        wide = $urandom_range(0, 1);
        for (int j = 0; j < NJOINT; j++) begin
            if (wide) begin
                r = $urandom_range(0, 32768);
                a = 0 - r;
                b = $urandom_range(0, 32767);
            end else begin
                r = $urandom_range(0, 65535);
                a = r - 32768;
                r = $urandom_range(0, 65535);
                b = r - 32768;
                if (a > b) begin
                    r = a;
                    a = b;
                    b = r;
                end
            end
            lo_v[16*j +: 16] = 16'(a);
            hi_v[16*j +: 16] = 16'(b);
            r = $urandom_range(0, b - a);
            st_v[16*j +: 16] = 16'(a + r);
            r = $urandom_range(0, b - a);
            gl_v[16*j +: 16] = 16'(a + r);
        end
        if ($urandom_range(0, 5) == 0) begin
            k = $urandom_range(0, NJOINT - 1);
            swap              = lo_v[16*k +: 16];
            lo_v[16*k +: 16]  = hi_v[16*k +: 16];
            hi_v[16*k +: 16]  = swap;
        end
        write_reg(CFG_LOWER, lo_v);
        write_reg(CFG_UPPER, hi_v);
        write_reg(CFG_START, st_v);
        write_reg(CFG_GOAL, gl_v);
        // Bits above each register's width are random junk; only the low bits count.
        junk = {$urandom, $urandom};
        case (cost_mode)
            COST_OPEN: begin
                junk[0] = 1'b1;
                write_reg(CFG_UNBOUNDED, junk);
            end
            default: begin
                junk[0] = 1'b0;
                write_reg(CFG_UNBOUNDED, junk);
                // Shortest possible path runs through the start: tie the bound to it.
                base = judge_candidate(st_v);
                case (cost_mode)
                    COST_ZERO: cost = '0;
                    COST_FULL: cost = LEN_CAP[LEN_W-1:0];
                    default:   cost = base.length + LEN_W'($urandom_range(0, 16384));
                endcase
                junk = {$urandom, $urandom};
                junk[LEN_W-1:0] = cost;
                write_reg(CFG_COST, junk);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: zero limits, zero start and goal, unbounded cost.
    // Writes to unmapped indexes must leave every register alone.
    task automatic test_reset_state();
        offer_candidate(pack4(0, 0, 0, 0));
        offer_candidate(pack4(0, 0, 0, 1));
        drain();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, 64'h5A5A_A5A5_0F0F_F0F0);
        offer_candidate(pack4(0, 0, 0, 0));
        drain();
    endtask

    // Limits are inclusive; one step past either side fails; inverted limits admit nothing.
    task automatic test_joint_limits();
        write_reg(CFG_LOWER, pack4(-4096, -32768, -1, 0));
        write_reg(CFG_UPPER, pack4(4096, 32767, -1, 8191));
        offer_candidate(pack4(-4096, -32768, -1, 0));
        offer_candidate(pack4(4096, 32767, -1, 8191));
        offer_candidate(pack4(4097, 0, -1, 0));
        offer_candidate(pack4(-4097, 0, -1, 0));
        offer_candidate(pack4(0, 0, -1, 8192));
        offer_candidate(pack4(0, 0, 0, 0));
        drain();
        write_reg(CFG_LOWER, pack4(-4096, -32768, -1, 100));
        write_reg(CFG_UPPER, pack4(4096, 32767, -1, 50));
        offer_candidate(pack4(0, 0, -1, 75));
        offer_candidate(pack4(0, 0, -1, 50));
        offer_candidate(pack4(0, 0, -1, 100));
        drain();
    endtask

    // Cost bound is strict, path length is reported whatever the verdict,
    // and excess bits of the cost and unbounded registers are dropped.
    task automatic test_cost_bound();
        write_reg(CFG_LOWER, pack4(-32768, -32768, -32768, -32768));
        write_reg(CFG_UPPER, pack4(32767, 32767, 32767, 32767));
        write_reg(CFG_START, '0);
        write_reg(CFG_GOAL, '0);
        write_reg(CFG_UNBOUNDED, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(CFG_COST, 64'hFFFF_FFFF_FFF8_0000 | 64'd8192);
        offer_candidate(pack4(4095, 0, 0, 0));      // 8190: just below the bound
        offer_candidate(pack4(4096, 0, 0, 0));      // 8192: equal, so outside
        offer_candidate(pack4(-4096, 0, 0, 0));
        offer_candidate(pack4(2048, 2048, 0, 0));   // roots round down
        drain();
        // Longest reachable path: every joint at the far end from start and goal.
        write_reg(CFG_COST, 64'(LEN_CAP));
        write_reg(CFG_START, pack4(32767, 32767, 32767, 32767));
        write_reg(CFG_GOAL, pack4(32767, 32767, 32767, 32767));
        offer_candidate(pack4(-32768, -32768, -32768, -32768));
        offer_candidate(pack4(32767, 32767, 32767, 32767));
        drain();
        write_reg(CFG_COST, '0);
        offer_candidate(pack4(32767, 32767, 32767, 32767));
        drain();
        // Limit failure under a loose bound: length still reported.
        write_reg(CFG_UPPER, pack4(0, 32767, 32767, 32767));
        write_reg(CFG_COST, 64'(LEN_CAP));
        offer_candidate(pack4(1, 0, 0, 0));
        drain();
        write_reg(CFG_UNBOUNDED, 64'd3);
        offer_candidate(pack4(0, -32768, -32768, -32768));
        drain();
    endtask

    // Random phases, each with its own configuration; one phase runs without idling.
    task automatic test_random_phases();
        t_cost_mode mode;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       mode = COST_OPEN;
                4:       mode = COST_FULL;
                6:       mode = COST_ZERO;
                default: mode = COST_NEAR;
            endcase
            idle_en = (ph != 2);
            load_random_phase(mode);
            repeat (PHASE_ITEMS) offer_candidate(gen_candidate());
            drain();
        end
    endtask

    // Closing stretch: transfers back to back on both sides.
    task automatic test_back_to_back();
        idle_en = 1'b0;
        load_random_phase(COST_NEAR);
        repeat (BURST_ITEMS) offer_candidate(gen_candidate());
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_LOWER;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.joint_0 = '0;
        in_ch.joint_1 = '0;
        in_ch.joint_2 = '0;
        in_ch.joint_3 = '0;
        lower_cfg     = '0;
        upper_cfg     = '0;
        start_cfg     = '0;
        goal_cfg      = '0;
        cost_cfg      = '0;
        unbounded_cfg = 1'b1;
        mismatch_count = 0;
        idle_en       = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_joint_limits();
        test_cost_bound();
        test_random_phases();
        test_back_to_back();

        // Catch any stray result trailing the last expected one.
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
